FILE: src/ackrx_pkg.sv
// Shared types, codes and the CRC-16/MODBUS byte update for the ack frame receiver.
`default_nettype none
package ackrx_pkg;

  // input word kinds (tuser)
  localparam logic [1:0] MODE_ARM  = 2'd0;
  localparam logic [1:0] MODE_BYTE = 2'd1;
  localparam logic [1:0] MODE_TICK = 2'd2;

  // result kinds
  localparam logic [1:0] OUT_ACK     = 2'd0;
  localparam logic [1:0] OUT_NACK    = 2'd1;
  localparam logic [1:0] OUT_TIMEOUT = 2'd2;

  // configuration register indexes
  localparam logic CFG_TIMEOUT_LIMIT = 1'b0;
  localparam logic CFG_ACK_CODE      = 1'b1;

  localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
  localparam logic [7:0]  ACK_RESET     = 8'h00;

  // frame constants
  localparam logic [7:0]  SYNC_FIRST  = 8'hAA;
  localparam logic [7:0]  SYNC_SECOND = 8'hBB;
  localparam logic [7:0]  FRAME_LEN   = 8'h06;
  localparam logic [15:0] CRC_INIT    = 16'hFFFF;
  localparam logic [15:0] CRC_POLY    = 16'hA001;
  localparam logic [15:0] MS_MAX      = 16'hFFFF;

  // one result word
  typedef struct packed {
    logic [1:0] outcome;
    logic [7:0] status;
    logic       crc_match;
  } res_t;

  // reflected CRC-16 update over one byte, unrolled over eight bit steps
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

FILE: src/ackrx_core.sv
// Frame parser, running CRC and millisecond counter; one input word per cycle while accept_i is high.
`default_nettype none
module ackrx_core import ackrx_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        accept_i,
  input  wire logic [1:0]  mode_i,
  input  wire logic [7:0]  rx_byte_i,
  input  wire logic [15:0] timeout_limit_i,
  input  wire logic [7:0]  ack_code_i,
  output logic             res_valid_o,
  output res_t             res_o
);

  // parser phases
  localparam logic [2:0] PH_HUNT   = 3'd0;
  localparam logic [2:0] PH_SYNC2  = 3'd1;
  localparam logic [2:0] PH_STATUS = 3'd2;
  localparam logic [2:0] PH_LEN    = 3'd3;
  localparam logic [2:0] PH_CRCH   = 3'd4;
  localparam logic [2:0] PH_CRCL   = 3'd5;

  logic        waiting_q, waiting_d;
  logic [2:0]  phase_q, phase_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  status_q, status_d;
  logic [7:0]  crch_q, crch_d;
  logic [15:0] elapsed_q, elapsed_d;

  logic [15:0] crc_upd;
  logic [15:0] elapsed_inc;
  logic        crc_ok;

  assign crc_upd     = crc_byte((phase_q == PH_SYNC2 || phase_q == PH_STATUS ||
                                 phase_q == PH_LEN) ? crc_q : CRC_INIT, rx_byte_i);
  assign elapsed_inc = (elapsed_q == MS_MAX) ? elapsed_q : elapsed_q + 16'd1;
  assign crc_ok      = ({crch_q, rx_byte_i} == crc_q);

  // next state and result for the word on the input
  always_comb begin
    waiting_d   = waiting_q;
    phase_d     = phase_q;
    crc_d       = crc_q;
    status_d    = status_q;
    crch_d      = crch_q;
    elapsed_d   = elapsed_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    if (accept_i) begin
      if (mode_i == MODE_ARM) begin
        waiting_d = 1'b1;
        phase_d   = PH_HUNT;
        crc_d     = CRC_INIT;
        elapsed_d = '0;
      end else if (waiting_q && mode_i == MODE_TICK) begin
        elapsed_d = elapsed_inc;
        if (elapsed_inc >= timeout_limit_i) begin
          res_valid_o   = 1'b1;
          res_o.outcome = OUT_TIMEOUT;
        end
      end else if (waiting_q && mode_i == MODE_BYTE) begin
        if (elapsed_q >= timeout_limit_i) begin
          res_valid_o   = 1'b1;
          res_o.outcome = OUT_TIMEOUT;
        end else begin
          case (phase_q)
            PH_SYNC2: begin
              if (rx_byte_i == SYNC_SECOND) begin
                crc_d   = crc_upd;
                phase_d = PH_STATUS;
              end else begin
                phase_d = PH_HUNT;
                crc_d   = CRC_INIT;
              end
            end
            PH_STATUS: begin
              status_d = rx_byte_i;
              crc_d    = crc_upd;
              phase_d  = PH_LEN;
            end
            PH_LEN: begin
              if (rx_byte_i == FRAME_LEN) begin
                crc_d   = crc_upd;
                phase_d = PH_CRCH;
              end else begin
                phase_d = PH_HUNT;
                crc_d   = CRC_INIT;
              end
            end
            PH_CRCH: begin
              crch_d  = rx_byte_i;
              phase_d = PH_CRCL;
            end
            PH_CRCL: begin
              res_valid_o     = 1'b1;
              res_o.outcome   = (crc_ok && status_q == ack_code_i) ? OUT_ACK : OUT_NACK;
              res_o.status    = status_q;
              res_o.crc_match = crc_ok;
            end
            default: begin
              // hunting (unused phases behave the same)
              if (rx_byte_i == SYNC_FIRST) begin
                crc_d   = crc_upd;
                phase_d = PH_SYNC2;
              end else begin
                crc_d   = CRC_INIT;
                phase_d = PH_HUNT;
              end
            end
          endcase
        end
      end
      // a report ends the wait
      if (res_valid_o) begin
        waiting_d = 1'b0;
        phase_d   = PH_HUNT;
        crc_d     = CRC_INIT;
      end
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      waiting_q <= 1'b0;
      phase_q   <= PH_HUNT;
      crc_q     <= CRC_INIT;
      status_q  <= '0;
      crch_q    <= '0;
      elapsed_q <= '0;
    end else begin
      waiting_q <= waiting_d;
      phase_q   <= phase_d;
      crc_q     <= crc_d;
      status_q  <= status_d;
      crch_q    <= crch_d;
      elapsed_q <= elapsed_d;
    end
  end

endmodule
`default_nettype wire

FILE: src/ackrx_out_reg.sv
// Output result register; takes a new result in the cycle the old one leaves.
`default_nettype none
module ackrx_out_reg import ackrx_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic load_i,
  input  res_t      res_i,
  input  wire logic m_ready_i,
  output logic      m_valid_o,
  output res_t      res_o,
  output logic      free_o
);

  logic valid_q, valid_d;
  res_t res_q;

  assign free_o    = !valid_q || m_ready_i;
  assign valid_d   = load_i || (valid_q && !m_ready_i);
  assign m_valid_o = valid_q;
  assign res_o     = res_q;

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

endmodule
`default_nettype wire

FILE: src/ack_frame_receiver_crc16_timeout.sv
// Top level of the acknowledge frame receiver with CRC-16 check and timeout.
//
//   channel  | dir | handshake                   | contents
//   s_axis   | in  | s_axis_tvalid/s_axis_tready | tuser mode, tdata rx_byte
//   m_axis   | out | m_axis_tvalid/m_axis_tready | tuser outcome, tdata status/crc flag
//   cfg      | in  | cfg_we_i, no wait           | timeout_limit, ack_code
//
// One word per cycle: the parser, unrolled byte CRC and ms counter sit between
// the input and the result register; a result shows in the cycle after its word.
// A stalled result holds s_axis_tready low until the result is taken.
// Reset clears the parser to idle and loads timeout_limit 1000, ack_code 0.
`default_nettype none
module ack_frame_receiver_crc16_timeout import ackrx_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,  // [7:0] rx_byte
  input  wire logic [1:0]  s_axis_tuser,  // [1:0] mode
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,  // [7:0] status_seen, [8] crc_matched, [15:9] zero
  output logic [1:0]       m_axis_tuser,  // [1:0] outcome
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_addr_i,
  input  wire logic [15:0] cfg_wdata_i
);

  logic [15:0] timeout_limit_q;
  logic [7:0]  ack_code_q;
  logic        accept;
  logic        res_valid;
  res_t        res;
  res_t        res_out;
  logic        free;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_limit_q <= TIMEOUT_RESET;
      ack_code_q      <= ACK_RESET;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_TIMEOUT_LIMIT: timeout_limit_q <= cfg_wdata_i;
        CFG_ACK_CODE:      ack_code_q      <= cfg_wdata_i[7:0];
        default:           ;
      endcase
    end
  end

  assign s_axis_tready = free;
  assign accept        = s_axis_tvalid && free;

  ackrx_core u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .mode_i          (s_axis_tuser),
    .rx_byte_i       (s_axis_tdata),
    .timeout_limit_i (timeout_limit_q),
    .ack_code_i      (ack_code_q),
    .res_valid_o     (res_valid),
    .res_o           (res)
  );

  ackrx_out_reg u_out (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (res_valid),
    .res_i     (res),
    .m_ready_i (m_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .res_o     (res_out),
    .free_o    (free)
  );

  assign m_axis_tuser = res_out.outcome;
  assign m_axis_tdata = {7'd0, res_out.crc_match, res_out.status};

  // input only stalls behind a waiting result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with no pending result");

  // timeout results carry no status and no crc match
  a_timeout_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == OUT_TIMEOUT) |-> (m_axis_tdata == 16'd0))
    else $error("timeout result with payload");

  // ack only with a matching crc
  a_ack_needs_crc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == OUT_ACK) |-> m_axis_tdata[8])
    else $error("ack without crc match");

  // an arm word never produces a result
  a_arm_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser == MODE_ARM) |=>
      !($rose(m_axis_tvalid)))
    else $error("result after arm word");

endmodule
`default_nettype wire
